// ----- hdl/sle_pkg.sv -----
package sle_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = 5;
  localparam int VAL_W = 32;
  localparam int MODE_W = 3;

  localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REPLACE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FIND    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ    = 3'd4;

  // command broadcast to every cell in the chain
  typedef struct packed {
    logic                    ins;
    logic                    del;
    logic [IDX_W-1:0]        del_idx;
    logic signed [VAL_W-1:0] value;
  } cell_cmd_t;

  // what a cell reports back to the control
  typedef struct packed {
    logic                    lt;
    logic                    eq;
    logic                    first;
    logic signed [VAL_W-1:0] entry;
  } cell_stat_t;

endpackage

// ----- hdl/sle_req_if.sv -----
interface sle_req_if;
  import sle_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [VAL_W-1:0]  value;
  logic [CNT_W-1:0]         position;

  modport source (output valid, output mode, output value, output position, input ready);
  modport sink (input valid, input mode, input value, input position, output ready);
endinterface

// ----- hdl/sle_rsp_if.sv -----
interface sle_rsp_if;
  import sle_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic [CNT_W-1:0]         found_position;
  logic signed [VAL_W-1:0]  read_value;
  logic [CNT_W-1:0]         entry_count;

  modport source (output valid, output ok, output found_position, output read_value,
                  output entry_count, input ready);
  modport sink (input valid, input ok, input found_position, input read_value,
                input entry_count, output ready);
endinterface

// ----- hdl/sle_cell.sv -----
module sle_cell
  import sle_pkg::*;
(
  input  logic                    clk,
  input  logic [IDX_W-1:0]        idx,
  input  logic [CNT_W-1:0]        count,
  input  cell_cmd_t               cmd,
  input  logic                    left_lt,
  input  logic signed [VAL_W-1:0] left_entry,
  input  logic signed [VAL_W-1:0] right_entry,
  output cell_stat_t              stat
);

  logic signed [VAL_W-1:0] entry;
  logic                    active;
  logic                    lt;

  assign active = {1'b0, idx} < count;
  assign lt     = active && (entry < cmd.value);

  assign stat.lt    = lt;
  assign stat.eq    = active && (entry == cmd.value);
  // boundary between smaller entries and the rest
  assign stat.first = !lt && left_lt;
  assign stat.entry = entry;

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (!lt) begin
        entry <= left_lt ? cmd.value : left_entry;
      end
    end else if (cmd.del) begin
      if (idx >= cmd.del_idx) begin
        entry <= right_entry;
      end
    end
  end

endmodule

// ----- hdl/sorted_list_engine.sv -----
// channel  dir  payload                                          handshake
// req      in   mode, value, position                            valid/ready
// rsp      out  ok, found_position, read_value, entry_count      valid/ready
//
// a request is taken by the row of cells; insert, delete, find and read
// load their result at the edge that accepts them, replace goes through
// S_IDLE (delete), then S_INSERT (sorted insert by the same cells)
// one output register holds the result; a new request is taken only when that
// register is empty or being read, so a stalled rsp holds off req
// rst is synchronous: count clears, entry contents stay undefined until written
module sorted_list_engine
  import sle_pkg::*;
(
  input logic      clk,
  input logic      rst,
  sle_req_if.sink  req,
  sle_rsp_if.source rsp
);

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_INSERT = 1'b1;

  logic                    state, state_next;
  logic [CNT_W-1:0]        count, count_next;
  logic signed [VAL_W-1:0] held_value;
  logic                    out_valid;
  logic                    out_free;
  logic                    accept;
  logic                    pos_ok;
  logic [IDX_W-1:0]        pos_idx;

  logic                    res_load;
  logic                    res_ok;
  logic [CNT_W-1:0]        res_found;
  logic signed [VAL_W-1:0] res_read;
  logic [CNT_W-1:0]        found_pos;
  logic                    found;

  cell_cmd_t               cmd;
  cell_stat_t              stat [CAPACITY];

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign accept    = req.valid && req.ready;
  assign pos_ok    = (req.position != '0) && (req.position <= count);
  assign pos_idx   = IDX_W'(req.position - CNT_W'(1));

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic                    left_lt;
      logic signed [VAL_W-1:0] left_entry;
      logic signed [VAL_W-1:0] right_entry;
      if (g == 0) begin : g_head
        assign left_lt    = 1'b1;
        assign left_entry = stat[g].entry;
      end else begin : g_body
        assign left_lt    = stat[g-1].lt;
        assign left_entry = stat[g-1].entry;
      end
      if (g == CAPACITY - 1) begin : g_tail
        assign right_entry = stat[g].entry;
      end else begin : g_mid
        assign right_entry = stat[g+1].entry;
      end
      sle_cell u_cell (
        .clk         (clk),
        .idx         (IDX_W'(g)),
        .count       (count),
        .cmd         (cmd),
        .left_lt     (left_lt),
        .left_entry  (left_entry),
        .right_entry (right_entry),
        .stat        (stat[g])
      );
    end
  endgenerate

  // list is sorted, so the first equal entry sits at the boundary
  always_comb begin
    found_pos = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (stat[k].first && stat[k].eq) begin
        found_pos = found_pos | CNT_W'(k + 1);
      end
    end
    found = found_pos != '0;
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    cmd.ins     = 1'b0;
    cmd.del     = 1'b0;
    cmd.del_idx = pos_idx;
    cmd.value   = (state == S_INSERT) ? held_value : req.value;
    res_load    = 1'b0;
    res_ok      = 1'b0;
    res_found   = '0;
    res_read    = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          res_load = 1'b1;
          case (req.mode)
            MODE_INSERT: begin
              if (count < CNT_W'(CAPACITY)) begin
                cmd.ins    = 1'b1;
                res_ok     = 1'b1;
                count_next = count + CNT_W'(1);
              end
            end
            MODE_DELETE: begin
              if (pos_ok) begin
                cmd.del    = 1'b1;
                res_ok     = 1'b1;
                count_next = count - CNT_W'(1);
              end
            end
            MODE_REPLACE: begin
              if (pos_ok) begin
                cmd.del    = 1'b1;
                count_next = count - CNT_W'(1);
                res_load   = 1'b0;
                state_next = S_INSERT;
              end
            end
            MODE_FIND: begin
              res_ok    = found;
              res_found = found_pos;
            end
            MODE_READ: begin
              if (pos_ok) begin
                res_ok   = 1'b1;
                res_read = stat[pos_idx].entry;
              end
            end
            default: ;
          endcase
        end
      end
      S_INSERT: begin
        // one slot was just freed, so this insert cannot fail
        if (out_free) begin
          cmd.ins    = 1'b1;
          res_load   = 1'b1;
          res_ok     = 1'b1;
          count_next = count + CNT_W'(1);
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_value <= req.value;
    end
    if (res_load) begin
      rsp.ok             <= res_ok;
      rsp.found_position <= res_found;
      rsp.read_value     <= res_read;
      rsp.entry_count    <= count_next;
    end
  end

  assign rsp.valid = out_valid;

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    accept && (req.mode == MODE_INSERT) && (count < CNT_W'(CAPACITY))
    |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the list");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (rst)
    accept && (req.mode == MODE_DELETE) && pos_ok
    |=> count == $past(count) - CNT_W'(1))
    else $error("delete did not shrink the list");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.found_position != '0) |-> rsp.ok)
    else $error("found position reported without ok");

endmodule

// ----- verif/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sle_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int BIAS_FILL = 0;
  localparam int BIAS_DRAIN = 1;
  localparam int BIAS_MIXED = 2;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic                    ok;
    logic [CNT_W-1:0]        found_position;
    logic signed [VAL_W-1:0] read_value;
    logic [CNT_W-1:0]        entry_count;
  } answer_t;

  // shadow of the sorted list plus the answers still owed by the block
  class sorted_list_model;
    logic signed [VAL_W-1:0] entries[CAPACITY];
    int                      fill;
    answer_t                 pending_answers[$];
    int                      mismatches;
    int                      n_requests;
    int                      n_answers;
    int                      n_full_refusals;
    int                      n_find_hits;
    int                      peak_fill;

    function new();
      fill = 0;
      mismatches = 0;
      n_requests = 0;
      n_answers = 0;
      n_full_refusals = 0;
      n_find_hits = 0;
      peak_fill = 0;
    endfunction

    function int outstanding();
      return pending_answers.size();
    endfunction

    // the new value goes ahead of equal values already stored
    function bit place_sorted(logic signed [VAL_W-1:0] v);
      int i;
      if (fill >= CAPACITY) return 1'b0;
      i = 0;
      while (i < fill && entries[i] < v) i++;
      for (int k = fill; k > i; k--) entries[k] = entries[k-1];
      entries[i] = v;
      fill++;
      return 1'b1;
    endfunction

    function void remove_at(int idx);
      for (int k = idx; k + 1 < fill; k++) entries[k] = entries[k+1];
      fill--;
    endfunction

    function void note_request(logic [MODE_W-1:0] m, logic signed [VAL_W-1:0] v,
                               logic [CNT_W-1:0] p);
      answer_t a;
      bit      pos_ok;
      a = '0;
      pos_ok = (p >= 1) && (p <= fill);
      n_requests++;
      case (m)
        MODE_INSERT: begin
          a.ok = place_sorted(v);
          if (!a.ok) n_full_refusals++;
        end
        MODE_DELETE: begin
          if (pos_ok) begin
            remove_at(int'(p) - 1);
            a.ok = 1'b1;
          end
        end
        MODE_REPLACE: begin
          if (pos_ok) begin
            remove_at(int'(p) - 1);
            a.ok = place_sorted(v);
          end
        end
        MODE_FIND: begin
          for (int i = 0; i < fill; i++) begin
            if (entries[i] == v) begin
              a.found_position = CNT_W'(i + 1);
              a.ok = 1'b1;
              n_find_hits++;
              break;
            end
          end
        end
        MODE_READ: begin
          if (pos_ok) begin
            a.read_value = entries[int'(p) - 1];
            a.ok = 1'b1;
          end
        end
        default: ;
      endcase
      a.entry_count = CNT_W'(fill);
      if (fill > peak_fill) peak_fill = fill;
      pending_answers.push_back(a);
    endfunction

    task flag_mismatch(string msg);
      mismatches++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_answer(logic ok, logic [CNT_W-1:0] fpos, logic signed [VAL_W-1:0] rval,
                      logic [CNT_W-1:0] cnt);
      answer_t want;
      n_answers++;
      if (pending_answers.size() == 0) begin
        flag_mismatch($sformatf("answer %0d arrived with no request outstanding", n_answers));
        return;
      end
      want = pending_answers.pop_front();
      if (ok !== want.ok)
        flag_mismatch($sformatf("answer %0d ok %b, want %b", n_answers, ok, want.ok));
      if (fpos !== want.found_position)
        flag_mismatch($sformatf("answer %0d found_position %0d, want %0d",
                                n_answers, fpos, want.found_position));
      if (rval !== want.read_value)
        flag_mismatch($sformatf("answer %0d read_value %0d, want %0d",
                                n_answers, rval, want.read_value));
      if (cnt !== want.entry_count)
        flag_mismatch($sformatf("answer %0d entry_count %0d, want %0d",
                                n_answers, cnt, want.entry_count));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;

  sorted_list_model model;

  sle_req_if req_ch();
  sle_rsp_if rsp_ch();

  sorted_list_engine DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d answers outstanding",
               cycle_count, model.outstanding());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready)
      model.note_request(req_ch.mode, req_ch.value, req_ch.position);
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready)
        model.check_answer(rsp_ch.ok, rsp_ch.found_position, rsp_ch.read_value,
                           rsp_ch.entry_count);
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // called at a rising edge; returns at the edge that takes the request
  task automatic send_request(input logic [MODE_W-1:0] m, input logic signed [VAL_W-1:0] v,
                              input logic [CNT_W-1:0] p);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode <= m;
    req_ch.value <= v;
    req_ch.position <= p;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // small pool makes duplicates common, stored values give find hits
  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 35) return $urandom_range(6) - 3;
    if (r < 50) begin
      case ($urandom_range(3))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return -1;
        default: return 0;
      endcase
    end
    if (r < 65 && model.fill > 0) return model.entries[$urandom_range(model.fill - 1)];
    return $urandom;
  endfunction

  task automatic random_request(input int bias);
    int                r;
    int                ins_pct;
    int                del_pct;
    int                n;
    logic [MODE_W-1:0] m;
    logic [CNT_W-1:0]  p;
    n = model.fill;
    case (bias)
      BIAS_FILL: begin
        ins_pct = 45;
        del_pct = 10;
      end
      BIAS_DRAIN: begin
        ins_pct = 10;
        del_pct = 45;
      end
      default: begin
        ins_pct = 28;
        del_pct = 28;
      end
    endcase
    r = $urandom_range(99);
    if (r < ins_pct) m = MODE_INSERT;
    else if (r < ins_pct + del_pct) m = MODE_DELETE;
    else if (r < ins_pct + del_pct + 14) m = MODE_REPLACE;
    else if (r < ins_pct + del_pct + 28) m = MODE_FIND;
    else if (r < ins_pct + del_pct + 38) m = MODE_READ;
    else m = MODE_W'($urandom_range(2**MODE_W - 1, int'(MODE_READ) + 1));
    if (n > 0 && $urandom_range(99) < 85) p = CNT_W'($urandom_range(n, 1));
    else p = CNT_W'($urandom_range(2**CNT_W - 1, 0));
    send_request(m, pick_value(), p);
  endtask

  task automatic run_directed();
    // empty list: nothing to delete, read or find
    send_request(MODE_DELETE, 0, 1);
    send_request(MODE_READ, 0, 1);
    send_request(MODE_FIND, 0, 0);
    send_request(MODE_INSERT, VAL_MAX, 0);
    send_request(MODE_INSERT, VAL_MIN, 0);
    send_request(MODE_INSERT, 0, 0);
    send_request(MODE_INSERT, 0, 0);
    send_request(MODE_INSERT, -1, 0);
    send_request(MODE_FIND, 0, 0);
    send_request(MODE_FIND, VAL_MAX, 0);
    send_request(MODE_READ, 0, 1);
    send_request(MODE_READ, 0, 5);
    // position zero, one past the end, and the top of the field
    send_request(MODE_READ, 0, 0);
    send_request(MODE_READ, 0, 6);
    send_request(MODE_READ, VAL_MAX, 31);
    send_request(MODE_REPLACE, VAL_MAX, 1);
    send_request(MODE_REPLACE, 5, 6);
    send_request(MODE_DELETE, 0, 0);
    send_request(MODE_DELETE, 0, 5);
    send_request(MODE_FIND, 7, 0);
    send_request(MODE_W'(int'(MODE_READ) + 1), 0, 1);
    send_request(MODE_W'(2**MODE_W - 1), VAL_MIN, 31);
    send_request(MODE_REPLACE, VAL_MIN, 4);
    send_request(MODE_DELETE, 0, 1);
  endtask

  initial begin
    int idle_plan[4];
    int stall_plan[4];
    int bias;
    idle_plan = '{0, 63, 0, 31};
    stall_plan = '{0, 0, 63, 31};
    bias = BIAS_MIXED;
    model = new();
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.mode <= MODE_INSERT;
    req_ch.value <= '0;
    req_ch.position <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_plan[ph];
      stall_pct = stall_plan[ph];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // runs of fill-heavy or drain-heavy traffic reach a full and an empty list
        if (n % 40 == 0) bias = $urandom_range(BIAS_MIXED, BIAS_FILL);
        random_request(bias);
      end
    end
    req_ch.valid <= 1'b0;
    // let the monitor note the last request before draining
    @(posedge clk);
    while (model.outstanding() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("ran %0d requests, checked %0d answers, list reached %0d of %0d entries",
             model.n_requests, model.n_answers, model.peak_fill, CAPACITY);
    $display("%0d inserts refused on a full list, %0d finds matched, %0d mismatches",
             model.n_full_refusals, model.n_find_hits, model.mismatches);
    if (model.mismatches == 0 && model.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
